/* rtl/bss_pkg.sv */
// shared constants and types for the byte substring search block
`default_nettype none

package bss_pkg;

    localparam int MAX_NEEDLE = 64;
    localparam int PW         = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = 6;
    localparam int OFS_W      = 32;

    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_HAYSTACK = 1'b1;

    // per-cell control, driven from the top level
    typedef struct packed {
        logic shift;   // take the next window byte
        logic ins;     // next byte is the incoming haystack byte
        logic active;  // cell lies inside the needle length
        logic nld;     // write the needle byte held by this cell
    } cell_ctrl_t;

    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] offset;
    } res_t;

endpackage

`default_nettype wire

/* rtl/byte_substring_search.sv */
// a result beat is registered in the result buffer and offered from its head entry
// throughput: one beat per cycle unless s_tready is low, which it is while the result
// buffer is full and while the ring realigns, one cell per cycle, after a length write
// reset: synchronous active-low aresetn clears the search state, the result buffer
// and needle_length; window and needle cells hold no reset
`default_nettype none

module byte_substring_search (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [6:0]  cfg_wr_data,   // needle_length
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,       // byte_value[7:0], needle_index[13:8], zero pad
    input  wire         s_tuser,       // kind
    input  wire         s_tlast,       // last_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,       // match_offset
    output logic        m_tuser        // found
);

    localparam int N  = bss_pkg::MAX_NEEDLE;
    localparam int PW = bss_pkg::PW;

    logic [bss_pkg::LEN_W-1:0] len_reg;
    logic [PW-1:0]             ptr_reg, tgt_reg, tgt_new;
    logic [31:0]               count_reg, cnt_n;
    logic                      reported_reg;
    logic                      realign, acc, hay_acc, ld_acc, full, hit, push;
    bss_pkg::res_t             push_res;
    logic [7:0]                hay_byte;
    logic [bss_pkg::IDX_W-1:0] ld_idx;
    logic [7:0]                win [N];
    logic [N-1:0]              ok;
    bss_pkg::cell_ctrl_t       ctrl [N];

    assign hay_byte = s_tdata[7:0];
    assign ld_idx   = s_tdata[13:8];
    assign realign  = (ptr_reg != tgt_reg);
    assign s_tready = !realign && !full;
    assign acc      = s_tvalid && s_tready;
    assign hay_acc  = acc && (s_tuser == bss_pkg::KIND_HAYSTACK);
    assign ld_acc   = acc && (s_tuser == bss_pkg::KIND_LOAD);

    // entry cell of the ring sits at needle_length-1, so cell j lines up with needle[j]
    always_comb begin
        if (cfg_wr_data == '0 || 32'(cfg_wr_data) > 32'(N)) begin
            tgt_new = PW'(N - 1);
        end else begin
            tgt_new = PW'(cfg_wr_data - 7'd1);
        end
    end

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_cell
            assign ctrl[j].shift  = hay_acc || realign;
            assign ctrl[j].ins    = hay_acc && (32'(ptr_reg) == j);
            assign ctrl[j].active = (j < 32'(len_reg));
            assign ctrl[j].nld    = ld_acc && (32'(ld_idx) == j);

            bss_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl[j]),
                .hay_byte (hay_byte),
                .ld_byte  (hay_byte),
                .nbr_byte (win[(j + 1) % N]),
                .win_byte (win[j]),
                .ok       (ok[j])
            );
        end
    endgenerate

    assign cnt_n = count_reg + 32'd1;
    assign hit   = !reported_reg && (len_reg != '0) && (32'(len_reg) <= 32'(N))
                   && (cnt_n >= 32'(len_reg)) && (&ok);

    always_comb begin
        push            = 1'b0;
        push_res.found  = 1'b0;
        push_res.offset = '0;
        if (hay_acc) begin
            if (hit) begin
                push            = 1'b1;
                push_res.found  = 1'b1;
                push_res.offset = cnt_n - 32'(len_reg);
            end else if (s_tlast && !reported_reg) begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            ptr_reg      <= PW'(N - 1);
            tgt_reg      <= PW'(N - 1);
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
                tgt_reg <= tgt_new;
            end
            // each idle rotation moves the whole window one cell down
            if (realign) begin
                ptr_reg <= (ptr_reg == '0) ? PW'(N - 1) : ptr_reg - PW'(1);
            end
            if (hay_acc) begin
                if (s_tlast) begin
                    count_reg    <= '0;
                    reported_reg <= 1'b0;
                end else begin
                    count_reg <= cnt_n;
                    if (hit) begin
                        reported_reg <= 1'b1;
                    end
                end
            end
        end
    end

    bss_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_res (push_res),
        .full     (full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_no_accept_realign: assert property (@(posedge aclk) disable iff (!aresetn)
        realign |-> !s_tready)
        else $error("beat taken while the window ring realigns");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
        else $error("not-found result with non-zero offset");

    a_search_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (hay_acc && s_tlast) |=> (count_reg == 32'd0 && !reported_reg))
        else $error("search state not cleared after last beat");

    a_hit_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (hay_acc && hit && !s_tlast) |=> reported_reg)
        else $error("match not recorded");

endmodule

`default_nettype wire

/* rtl/bss_cell.sv */
// one window cell: a haystack byte, a needle byte and their compare
`default_nettype none

module bss_cell (
    input  wire                      aclk,
    input  wire bss_pkg::cell_ctrl_t ctrl,
    input  wire  [7:0]               hay_byte,
    input  wire  [7:0]               ld_byte,
    input  wire  [7:0]               nbr_byte,
    output logic [7:0]               win_byte,
    output logic                     ok
);

    logic [7:0] win_reg;
    logic [7:0] needle_reg;
    logic [7:0] win_next;

    assign win_next = ctrl.ins ? hay_byte : nbr_byte;
    assign win_byte = win_reg;
    // compare against the window as it stands after this beat
    assign ok       = !ctrl.active || (win_next == needle_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            win_reg <= win_next;
        end
        if (ctrl.nld) begin
            needle_reg <= ld_byte;
        end
    end

endmodule

`default_nettype wire

/* rtl/bss_out_buf.sv */
// two-entry result buffer in front of the master side
`default_nettype none

module bss_out_buf (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  wire bss_pkg::res_t push_res,
    output logic               full,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [31:0]        m_tdata,   // match_offset
    output logic               m_tuser    // found
);

    bss_pkg::res_t e0_reg, e1_reg, e0_next, e1_next;
    logic          v0_reg, v1_reg, v0_next, v1_next;
    logic          pop;

    assign pop      = v0_reg && m_tready;
    assign full     = v1_reg;
    assign m_tvalid = v0_reg;
    assign m_tdata  = e0_reg.offset;
    assign m_tuser  = e0_reg.found;

    always_comb begin
        e0_next = pop ? e1_reg : e0_reg;
        v0_next = pop ? v1_reg : v0_reg;
        e1_next = e1_reg;
        v1_next = pop ? 1'b0 : v1_reg;
        if (push) begin
            if (!v0_next) begin
                e0_next = push_res;
                v0_next = 1'b1;
            end else begin
                e1_next = push_res;
                v1_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

endmodule

`default_nettype wire

/* sim/byte_substring_search_tb.sv */
// self-checking testbench for the byte substring search block
`timescale 1ns / 1ps

module byte_substring_search_tb;

    localparam int MAX_NEEDLE = bss_pkg::MAX_NEEDLE;
    localparam int IDX_W      = bss_pkg::IDX_W;
    localparam int LEN_W      = bss_pkg::LEN_W;
    localparam int OFS_W      = bss_pkg::OFS_W;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           byte_value;
        logic [IDX_W-1:0]     needle_index;
        logic                 last_byte;
    } beat_t;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata     = '0;
    logic              s_tuser     = 1'b0;
    logic              s_tlast     = 1'b0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [OFS_W-1:0]  m_tdata;
    logic              m_tuser;

    byte_substring_search DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // search model state, advanced on every accepted input beat
    logic [7:0]        needle_mem [MAX_NEEDLE];
    logic [7:0]        window_mem [MAX_NEEDLE];
    logic [OFS_W-1:0]  hay_count = '0;
    logic              hit_flag  = 1'b0;
    logic [LEN_W-1:0]  len_reg   = '0;
    bss_pkg::res_t     verdict_q [$];

    // stimulus side
    beat_t             beat_q [$];
    beat_t             cur_beat;
    logic [7:0]        needle_plan [MAX_NEEDLE];
    logic [7:0]        alpha [2];
    int                beats_queued = 0;
    int                beats_sent   = 0;
    int                found_seen   = 0;
    int                miss_seen    = 0;
    int                cfg_writes   = 0;
    int                errors       = 0;
    int                tx_idle_pct  = 0;
    int                rx_idle_pct  = 0;
    int                tx_gap       = 0;
    int                rx_stall     = 0;
    int                holds_asked  = 0;
    int                holds_done   = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic flag_error(input string what);
        $display("[%0t] ERROR %s", $time, what);
        errors++;
    endtask

    function automatic void clear_search();
        hay_count = '0;
        hit_flag  = 1'b0;
        foreach (window_mem[k]) window_mem[k] = 8'h00;
    endfunction

    function automatic bit window_holds_needle();
        int j;
        if (len_reg == 0 || len_reg > MAX_NEEDLE || hay_count < len_reg)
            return 1'b0;
        for (j = 0; j < len_reg; j++) begin
            if (window_mem[len_reg - 1 - j] != needle_mem[j])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void advance_search(beat_t b);
        bss_pkg::res_t r;
        bit            was_hit;
        bit            hit_now;
        int            j;
        if (b.kind == bss_pkg::KIND_LOAD) begin
            needle_mem[b.needle_index] = b.byte_value;
            return;
        end
        for (j = MAX_NEEDLE - 1; j > 0; j--) window_mem[j] = window_mem[j - 1];
        window_mem[0] = b.byte_value;
        hay_count++;
        was_hit = hit_flag;
        hit_now = !was_hit && window_holds_needle();
        if (hit_now) begin
            r.found  = 1'b1;
            r.offset = hay_count - OFS_W'(len_reg);
            verdict_q.push_back(r);
        end else if (b.last_byte && !was_hit) begin
            r.found  = 1'b0;
            r.offset = '0;
            verdict_q.push_back(r);
        end
        if (b.last_byte)
            clear_search();
        else if (hit_now)
            hit_flag = 1'b1;
    endfunction

    // input side: offers queued beats, with random idle bursts
    always @(posedge aclk) begin
        logic offer;
        offer = 1'b0;
        if (!aresetn) begin
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_search(cur_beat);
                beats_sent++;
            end
            if (s_tvalid && !s_tready) begin
                offer = 1'b1;
            end else if (tx_gap > 0) begin
                tx_gap--;
            end else if (beat_q.size() != 0) begin
                if ($urandom_range(0, 99) < tx_idle_pct) begin
                    tx_gap = $urandom_range(0, 6);
                end else begin
                    cur_beat = beat_q.pop_front();
                    s_tdata  <= {2'b00, cur_beat.needle_index, cur_beat.byte_value};
                    s_tuser  <= cur_beat.kind;
                    s_tlast  <= cur_beat.last_byte;
                    offer    = 1'b1;
                end
            end
        end
        s_tvalid <= offer;
    end

    // result side ready: random stalls plus the long hold when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (holds_asked > holds_done) begin
            holds_done++;
            rx_stall = 150;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            rx_stall = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        bss_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                flag_error($sformatf("unexpected result beat found=%0b offset=%0d",
                                     m_tuser, m_tdata));
            end else begin
                want = verdict_q.pop_front();
                if (m_tuser !== want.found)
                    flag_error($sformatf("found flag %0b, expected %0b", m_tuser, want.found));
                if (m_tdata !== want.offset)
                    flag_error($sformatf("offset %0d, expected %0d", m_tdata, want.offset));
                if (want.found)
                    found_seen++;
                else
                    miss_seen++;
            end
        end
    end

    task automatic queue_load(input int idx, input logic [7:0] val, input bit last);
        beat_t b;
        b.kind         = bss_pkg::KIND_LOAD;
        b.byte_value   = val;
        b.needle_index = IDX_W'(idx);
        b.last_byte    = last;
        needle_plan[idx] = val;
        beat_q.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_hay(input logic [7:0] val, input bit last);
        beat_t b;
        b.kind         = bss_pkg::KIND_HAYSTACK;
        b.byte_value   = val;
        b.needle_index = IDX_W'($urandom_range(0, 63));
        b.last_byte    = last;
        beat_q.push_back(b);
        beats_queued++;
    endtask

    task automatic wait_idle();
        while (beat_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(negedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_needle_length(input logic [LEN_W-1:0] v);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        len_reg      = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) != 0)
            return alpha[$urandom_range(0, 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // one haystack run ending on a marked last byte, maybe with the needle planted
    task automatic run_search(input int n, input bit plant);
        logic [7:0] hay [$];
        int         pos;
        int         i;
        for (i = 0; i < n; i++) hay.push_back(pick_byte());
        if (plant && len_reg >= 1 && len_reg <= MAX_NEEDLE && n >= len_reg) begin
            pos = $urandom_range(0, n - len_reg);
            for (i = 0; i < len_reg; i++) hay[pos + i] = needle_plan[i];
        end
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0)
                queue_load($urandom_range(0, 63), pick_byte(), 1'($urandom_range(0, 1)));
            queue_hay(hay[i], i == n - 1);
        end
    endtask

    initial begin
        int  L;
        int  r;
        int  i;
        int  s;
        foreach (needle_mem[k]) needle_mem[k] = 8'h00;
        foreach (needle_plan[k]) needle_plan[k] = 8'h00;
        clear_search();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // zero length after reset never matches
        queue_hay(8'h00, 1'b1);
        queue_load(0, 8'h00, 1'b0);
        queue_load(1, 8'hFF, 1'b0);
        queue_load(2, 8'h5A, 1'b1);   // last flag on a load beat is ignored
        queue_load(63, 8'hC3, 1'b0);
        set_needle_length(7'd3);
        // match that ends on the final byte
        queue_hay(8'hFF, 1'b0);
        queue_hay(8'h00, 1'b0);
        queue_hay(8'hFF, 1'b0);
        queue_hay(8'h5A, 1'b1);
        // bytes after a match stay silent, the last one included
        queue_hay(8'h00, 1'b0);
        queue_hay(8'hFF, 1'b0);
        queue_hay(8'h5A, 1'b0);
        queue_hay(8'h11, 1'b0);
        queue_hay(8'h22, 1'b1);
        // haystack shorter than the needle
        queue_hay(8'h00, 1'b1);
        // needle rewritten part way through a search
        queue_hay(8'h00, 1'b0);
        queue_load(2, 8'h77, 1'b0);
        queue_hay(8'hFF, 1'b0);
        queue_hay(8'h77, 1'b1);
        // length beyond the store never matches
        set_needle_length(7'd127);
        queue_hay(8'h00, 1'b0);
        queue_hay(8'hFF, 1'b0);
        queue_hay(8'h77, 1'b1);

        // random part: fill the whole needle store first
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        for (i = 0; i < MAX_NEEDLE; i++) queue_load(i, 8'($urandom_range(0, 255)), 1'b0);
        while (beats_queued < 900) begin
            r = $urandom_range(0, 19);
            if (r == 0)      L = 0;
            else if (r == 1) L = MAX_NEEDLE;
            else if (r == 2) L = $urandom_range(MAX_NEEDLE + 1, 127);
            else if (r == 3) L = $urandom_range(7, MAX_NEEDLE - 1);
            else             L = $urandom_range(1, 6);
            alpha[0] = 8'($urandom_range(0, 255));
            alpha[1] = 8'($urandom_range(0, 255));
            tx_idle_pct = $urandom_range(0, 3) * 10;
            rx_idle_pct = $urandom_range(0, 3) * 10;
            set_needle_length(LEN_W'(L));
            for (i = 0; i < L && i < MAX_NEEDLE; i++) queue_load(i, pick_byte(), 1'b0);
            s = $urandom_range(2, 6);
            for (i = 0; i < s; i++)
                run_search($urandom_range(1, (L >= 1 && L <= MAX_NEEDLE) ? L + 8 : 10),
                           $urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) == 0)
                wait_idle();
        end

        // long receiver hold with one-byte searches, every fifth of which misses
        set_needle_length(7'd1);
        queue_load(0, 8'h3C, 1'b0);
        holds_asked++;
        for (i = 0; i < 40; i++) queue_hay((i % 5 == 4) ? 8'hC3 : 8'h3C, 1'b1);

        // closing stretch with no idling on either side
        wait_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        alpha[0] = 8'hA5;
        alpha[1] = 8'h5A;
        set_needle_length(LEN_W'($urandom_range(2, 5)));
        for (i = 0; i < len_reg; i++) queue_load(i, pick_byte(), 1'b0);
        for (i = 0; i < 10; i++) run_search($urandom_range(1, 12), 1'b1);

        wait_idle();
        repeat (10) @(posedge aclk);
        while (verdict_q.size() != 0) begin
            flag_error($sformatf("result never arrived, found=%0b offset=%0d",
                                 verdict_q[0].found, verdict_q[0].offset));
            void'(verdict_q.pop_front());
        end
        $display("%0d beats sent, %0d hits and %0d misses checked over %0d length settings",
                 beats_sent, found_seen, miss_seen, cfg_writes);
        $display("zero and over-range lengths, needle rewrites mid-search, one long output hold");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/bss_pkg.sv
rtl/bss_cell.sv
rtl/bss_out_buf.sv
rtl/byte_substring_search.sv
sim/byte_substring_search_tb.sv
